>>> design/lld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_pkg
// Shared types, register map, mode codes and helper functions of the
// landing and fall detector.
// ----------------------------------------------------------------------------
package lld_pkg;

    // Geometry
    localparam int LEGS           = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int QBITS          = 16;   // quotient bits of one mean division
    localparam int CFG_W          = 16;   // widest configuration register
    localparam int CFG_IDX_W      = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_AVG_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_TRIGGER = 3'd4;

    // Register reset values
    localparam logic [15:0] AVG_TICKS_RST    = 16'd500;
    localparam logic [14:0] TILT_LIMIT_RST   = 15'd6434;
    localparam logic [15:0] FALL_TICKS_RST   = 16'd100;
    localparam logic [15:0] LAND_TICKS_RST   = 16'd100;
    localparam logic [14:0] KNEE_TRIGGER_RST = 15'd192;   // 0.75 N.m in Q8.8

    // Opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_ENTER = 1'b1;

    // Mode codes
    localparam logic [2:0] MODE_LIFTED     = 3'd0;
    localparam logic [2:0] MODE_DAMPER     = 3'd1;
    localparam logic [2:0] MODE_RECOVERY   = 3'd2;
    localparam logic [2:0] MODE_OFF        = 3'd3;
    localparam logic [2:0] MODE_LOCOMOTION = 3'd4;
    localparam logic [2:0] MODE_QP_STAND   = 3'd5;
    localparam logic [2:0] MODE_RESET      = 3'd6;
    localparam logic [2:0] MODE_BAD        = 3'd7;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] knee_torque_0;
        logic signed [15:0] knee_torque_1;
        logic signed [15:0] knee_torque_2;
        logic signed [15:0] knee_torque_3;
        logic [2:0]         requested_mode;
    } tick_t;

    typedef struct packed {
        logic       ready_res;
        logic       landed;
        logic       fallen;
        logic       gait_select;
        logic [2:0] next_mode;
        logic       switch_done;
        logic       bad_request;
    } result_t;

    typedef struct packed {
        logic [2:0] next_mode;
        logic       switch_done;
        logic       bad_request;
    } mode_sel_t;

    // Magnitude of a 17-bit signed value (never the most negative code here)
    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        logic signed [16:0] n;
        n = -v;
        return v[16] ? 17'(n) : 17'(v);
    endfunction

    // Mode transition decision from the updated flags
    function automatic mode_sel_t select_mode(input logic [2:0] mode,
                                              input logic       rdy,
                                              input logic       landing,
                                              input logic       falling);
        mode_sel_t s;
        s = '{next_mode: MODE_LIFTED, switch_done: 1'b0, bad_request: 1'b0};
        case (mode) inside
            MODE_DAMPER, MODE_RECOVERY, MODE_OFF:
            begin
                s.next_mode   = mode;
                s.switch_done = 1'b1;
            end
            MODE_LOCOMOTION, MODE_QP_STAND:
            begin
                if (rdy && landing)
                begin
                    s.next_mode   = mode;
                    s.switch_done = 1'b1;
                end
            end
            MODE_RESET:
            begin
                if (rdy && falling)
                begin
                    s.next_mode   = mode;
                    s.switch_done = 1'b1;
                end
            end
            MODE_BAD:
            begin
                s.bad_request = 1'b1;
            end
            default:
            begin
                s.next_mode = MODE_LIFTED;
            end
        endcase
        return s;
    endfunction

endpackage

>>> design/lld_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface lld_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/lift_landing_fall_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lift_landing_fall_detector
// Landing and fall detector for a lifted legged robot. Averages the resting
// knee torques, then counts tilted or knee-triggered ticks toward falling or
// landing and decides the mode transition.
// ----------------------------------------------------------------------------
// Control and enter ticks give their result in the cycle after acceptance.
// Averaging ticks keep the block busy: a bit-serial shift-add multiply of
// mean by (n-1), a rounding set-up step, then a radix-2 division by n, one
// quotient bit per cycle, all legs in lanes.
// Throughput: one non-averaging tick per cycle while results are taken.
// Reset: registers take default values, counters/flags/means clear; no sweep.
// ----------------------------------------------------------------------------
module lift_landing_fall_detector
    import lld_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    lld_stream_if.sink              tick,
    lld_stream_if.source            result
);

    localparam int CW        = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int SW        = COUNT_BITS + QBITS;   // product/sum width
    localparam int STEPS_MAX = (COUNT_BITS > QBITS) ? COUNT_BITS : QBITS;
    localparam int STEP_W    = $clog2(STEPS_MAX);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Configuration registers
    logic [15:0] avg_ticks_reg;
    logic [14:0] tilt_limit_reg;
    logic [15:0] fall_ticks_reg;
    logic [15:0] land_ticks_reg;
    logic [14:0] knee_trigger_reg;

    // Detector state
    logic [COUNT_BITS-1:0] avg_count_reg, avg_count_next;
    logic [COUNT_BITS-1:0] fall_count_reg, fall_count_next;
    logic [COUNT_BITS-1:0] land_count_reg, land_count_next;
    logic                  landing_reg, landing_next;
    logic                  falling_reg, falling_next;
    logic                  ready_flag_reg, ready_flag_next;
    logic                  gait_reg, gait_next;
    logic signed [15:0]    knee_mean_reg [LEGS];

    // Sequencer and serial datapath
    logic [2:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [COUNT_BITS-1:0] mult_reg, mult_next;       // n-1, MSB first
    logic [2:0]            mode_reg;
    logic signed [15:0]    x_reg   [LEGS];
    logic signed [SW-1:0]  acc_reg [LEGS];
    logic [COUNT_BITS-1:0] rem_reg [LEGS];
    logic [QBITS-1:0]      lo_reg  [LEGS];
    logic                  neg_reg [LEGS];

    // Output register
    logic    out_valid_reg;
    result_t out_data_reg;

    logic               accept;
    logic               slot_free;
    logic               averaging;
    logic               tilted;
    logic               knee_hit;
    logic               load_now;
    logic               load_done;
    logic signed [15:0] knee_in [LEGS];
    logic [LEGS-1:0]    lane_hit;
    logic [COUNT_BITS-1:0] fall_inc, land_inc;
    mode_sel_t          sel_now, sel_done;

    assign slot_free  = !out_valid_reg || result.ready;
    assign tick.ready = (state_reg == S_IDLE) && slot_free;
    assign accept     = tick.valid && tick.ready;

    assign knee_in[0] = tick.data.knee_torque_0;
    assign knee_in[1] = tick.data.knee_torque_1;
    assign knee_in[2] = tick.data.knee_torque_2;
    assign knee_in[3] = tick.data.knee_torque_3;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_ticks_reg    <= AVG_TICKS_RST;
            tilt_limit_reg   <= TILT_LIMIT_RST;
            fall_ticks_reg   <= FALL_TICKS_RST;
            land_ticks_reg   <= LAND_TICKS_RST;
            knee_trigger_reg <= KNEE_TRIGGER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AVG_TICKS:    avg_ticks_reg    <= cfg_data;
                REG_TILT_LIMIT:   tilt_limit_reg   <= cfg_data[14:0];
                REG_FALL_TICKS:   fall_ticks_reg   <= cfg_data;
                REG_LAND_TICKS:   land_ticks_reg   <= cfg_data;
                REG_KNEE_TRIGGER: knee_trigger_reg <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // Tick classification: tilt and per-leg knee trigger
    always_comb
    begin
        tilted = (abs17(17'(tick.data.roll))  > {2'b00, tilt_limit_reg}) ||
                 (abs17(17'(tick.data.pitch)) > {2'b00, tilt_limit_reg});
        for (int i = 0; i < LEGS; i++)
        begin
            lane_hit[i] =
                (abs17(17'(knee_in[i]) - 17'(knee_mean_reg[i])) >= {2'b00, knee_trigger_reg}) ||
                (abs17(17'(knee_in[i])) >= {2'b00, knee_trigger_reg});
        end
        knee_hit  = |lane_hit;
        averaging = (CW'(avg_count_reg) < CW'(avg_ticks_reg)) && (avg_count_reg != CNT_MAX);
        fall_inc  = (fall_count_reg == CNT_MAX) ? CNT_MAX : fall_count_reg + 1'b1;
        land_inc  = (land_count_reg == CNT_MAX) ? CNT_MAX : land_count_reg + 1'b1;
    end

    // Flag and counter update for an accepted transaction
    always_comb
    begin
        avg_count_next  = avg_count_reg;
        fall_count_next = fall_count_reg;
        land_count_next = land_count_reg;
        landing_next    = landing_reg;
        falling_next    = falling_reg;
        ready_flag_next = ready_flag_reg;
        gait_next       = gait_reg;
        load_now        = 1'b0;
        if (accept)
        begin
            if (tick.data.opcode == OP_ENTER)
            begin
                ready_flag_next = 1'b0;
                avg_count_next  = '0;
                fall_count_next = '0;
                land_count_next = '0;
                load_now        = 1'b1;
            end
            else if (averaging)
            begin
                avg_count_next = avg_count_reg + 1'b1;
            end
            else if (tilted)
            begin
                land_count_next = '0;
                landing_next    = 1'b0;
                gait_next       = 1'b1;
                fall_count_next = fall_inc;
                falling_next    = CW'(fall_inc) >= CW'(fall_ticks_reg);
                ready_flag_next = falling_next;
                load_now        = 1'b1;
            end
            else
            begin
                fall_count_next = '0;
                falling_next    = 1'b0;
                gait_next       = 1'b0;
                landing_next    = knee_hit;
                land_count_next = knee_hit ? land_inc : '0;
                ready_flag_next = CW'(land_count_next) >= CW'(land_ticks_reg);
                load_now        = 1'b1;
            end
        end
    end

    // Sequencer for the mean update
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mult_next  = mult_reg;
        load_done  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (tick.data.opcode == OP_TICK) && averaging)
                begin
                    state_next = S_MUL;
                    step_next  = '0;
                    mult_next  = avg_count_reg;
                end
            end
            S_MUL:
            begin
                mult_next = mult_reg << 1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(COUNT_BITS - 1))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(QBITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    load_done  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            avg_count_reg  <= '0;
            fall_count_reg <= '0;
            land_count_reg <= '0;
            landing_reg    <= 1'b0;
            falling_reg    <= 1'b0;
            ready_flag_reg <= 1'b0;
            gait_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            avg_count_reg  <= avg_count_next;
            fall_count_reg <= fall_count_next;
            land_count_reg <= land_count_next;
            landing_reg    <= landing_next;
            falling_reg    <= falling_next;
            ready_flag_reg <= ready_flag_next;
            gait_reg       <= gait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg <= mult_next;
        if (accept)
        begin
            mode_reg <= tick.data.requested_mode;
        end
    end

    // Per-leg lanes: shift-add multiply, rounding set-up, restoring division
    for (genvar g = 0; g < LEGS; g++)
    begin : g_lane
        logic signed [SW-1:0]   sum;
        logic [SW-1:0]          mag;
        logic [SW-1:0]          dividend;
        logic [COUNT_BITS:0]    trial;
        logic                   fits;
        logic [COUNT_BITS:0]    diff;
        logic signed [SW-1:0]   mean_ext;
        logic [QBITS-1:0]       q_neg;

        always_comb
        begin
            mean_ext = SW'(knee_mean_reg[g]);
            sum      = acc_reg[g] + SW'(x_reg[g]);
            mag      = sum[SW-1] ? SW'(-sum) : SW'(sum);
            dividend = mag + SW'(avg_count_reg >> 1);
            trial    = {rem_reg[g], lo_reg[g][QBITS-1]};
            fits     = trial >= {1'b0, avg_count_reg};
            diff     = trial - {1'b0, avg_count_reg};
            q_neg    = QBITS'(-lo_reg[g]);
        end

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                x_reg[g]   <= knee_in[g];
                acc_reg[g] <= '0;
            end
            else if (state_reg == S_MUL)
            begin
                acc_reg[g] <= (acc_reg[g] <<< 1) +
                              (mult_reg[COUNT_BITS-1] ? mean_ext : SW'(0));
            end

            if (state_reg == S_PREP)
            begin
                neg_reg[g] <= sum[SW-1];
                rem_reg[g] <= dividend[SW-1:QBITS];
                lo_reg[g]  <= dividend[QBITS-1:0];
            end
            else if (state_reg == S_DIV)
            begin
                rem_reg[g] <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                lo_reg[g]  <= {lo_reg[g][QBITS-2:0], fits};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                knee_mean_reg[g] <= '0;
            end
            else if (load_done)
            begin
                knee_mean_reg[g] <= neg_reg[g] ? signed'(q_neg) : signed'(lo_reg[g]);
            end
        end
    end

    // Result register
    assign sel_now  = select_mode(tick.data.requested_mode, ready_flag_next,
                                  landing_next, falling_next);
    assign sel_done = select_mode(mode_reg, ready_flag_reg, landing_reg, falling_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_now || load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_now)
        begin
            out_data_reg <= '{ready_res:   ready_flag_next,
                               landed:      landing_next,
                               fallen:      falling_next,
                               gait_select: gait_next,
                               next_mode:   sel_now.next_mode,
                               switch_done: sel_now.switch_done,
                               bad_request: sel_now.bad_request};
        end
        else if (load_done)
        begin
            out_data_reg <= '{ready_res:   ready_flag_reg,
                               landed:      landing_reg,
                               fallen:      falling_reg,
                               gait_select: gait_reg,
                               next_mode:   sel_done.next_mode,
                               switch_done: sel_done.switch_done,
                               bad_request: sel_done.bad_request};
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Checks
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !tick.ready)
        else $error("tick accepted while a mean update is in progress");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(landing_reg && falling_reg))
        else $error("landing and falling flags both set");

    a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (tick.data.opcode == OP_ENTER)) |=>
            (fall_count_reg == '0) && (land_count_reg == '0) && !ready_flag_reg &&
            out_valid_reg && !out_data_reg.ready_res)
        else $error("enter command did not clear counters");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (step_reg <= STEP_W'(QBITS - 1)))
        else $error("division ran past its quotient width");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && slot_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished mean update gave no result");

endmodule

>>> verif/lld_detector_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lld_detector_checker
// Watches the tick and result channels and the register port of the landing
// and fall detector, predicts each result from its own copy of the detector
// state and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module lld_detector_checker
    import lld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 tick_valid,
    input  logic                 tick_ready,
    input  tick_t                tick_data,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  result_t              result_data,
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked,
    output int                   falls_seen,
    output int                   landings_seen,
    output int                   grants_seen
);

    localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;

    // Shadow copies of the registers
    int avg_ticks_r, tilt_limit_r, fall_ticks_r, land_ticks_r, knee_trigger_r;

    // Predicted detector state
    int   avg_cnt, fall_cnt, land_cnt;
    int   knee_avg [LEGS];
    logic landing_q, falling_q, ready_q, gait_q;

    // Results still owed by the block, oldest first
    result_t owed_results [$];

    function automatic int abs_i(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int bump(input int c);
        return (c >= CNT_MAX) ? CNT_MAX : c + 1;
    endfunction

    // Running mean, rounded to nearest with ties away from zero
    function automatic int rounded_mean(input int avg, input int x, input int n);
        longint sum, mag, q;
        sum = longint'(avg) * longint'(n - 1) + longint'(x);
        mag = (sum < 0) ? -sum : sum;
        q   = (mag + longint'(n / 2)) / longint'(n);
        return (sum < 0) ? -int'(q) : int'(q);
    endfunction

    // One tick through the detector: update state, form the result
    task automatic advance_detector(input tick_t t, output result_t r);
        int   kt [LEGS];
        int   roll_v, pitch_v;
        logic hit;
        kt[0]   = $signed(t.knee_torque_0);
        kt[1]   = $signed(t.knee_torque_1);
        kt[2]   = $signed(t.knee_torque_2);
        kt[3]   = $signed(t.knee_torque_3);
        roll_v  = $signed(t.roll);
        pitch_v = $signed(t.pitch);
        r       = '0;

        if (t.opcode == OP_ENTER)
        begin
            ready_q  = 1'b0;
            avg_cnt  = 0;
            fall_cnt = 0;
            land_cnt = 0;
        end
        else if (avg_cnt < avg_ticks_r && avg_cnt < CNT_MAX)
        begin
            avg_cnt++;
            for (int i = 0; i < LEGS; i++)
                knee_avg[i] = rounded_mean(knee_avg[i], kt[i], avg_cnt);
        end
        else if (abs_i(roll_v) > tilt_limit_r || abs_i(pitch_v) > tilt_limit_r)
        begin
            land_cnt  = 0;
            landing_q = 1'b0;
            gait_q    = 1'b1;
            fall_cnt  = bump(fall_cnt);
            falling_q = (fall_cnt >= fall_ticks_r);
            ready_q   = falling_q;
        end
        else
        begin
            hit = 1'b0;
            for (int i = 0; i < LEGS; i++)
                if (abs_i(kt[i] - knee_avg[i]) >= knee_trigger_r ||
                    abs_i(kt[i]) >= knee_trigger_r)
                    hit = 1'b1;
            fall_cnt  = 0;
            falling_q = 1'b0;
            gait_q    = 1'b0;
            landing_q = hit;
            land_cnt  = hit ? bump(land_cnt) : 0;
            ready_q   = (land_cnt >= land_ticks_r);
        end

        // Mode decision from the updated flags
        r.next_mode = MODE_LIFTED;
        case (t.requested_mode) inside
            MODE_DAMPER, MODE_RECOVERY, MODE_OFF:
            begin
                r.next_mode   = t.requested_mode;
                r.switch_done = 1'b1;
            end
            MODE_LOCOMOTION, MODE_QP_STAND:
            begin
                if (ready_q && landing_q)
                begin
                    r.next_mode   = t.requested_mode;
                    r.switch_done = 1'b1;
                end
            end
            MODE_RESET:
            begin
                if (ready_q && falling_q)
                begin
                    r.next_mode   = t.requested_mode;
                    r.switch_done = 1'b1;
                end
            end
            MODE_BAD:
            begin
                r.bad_request = 1'b1;
            end
            default:
            begin
                r.next_mode = MODE_LIFTED;
            end
        endcase

        r.ready_res   = ready_q;
        r.landed      = landing_q;
        r.fallen      = falling_q;
        r.gait_select = gait_q;
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Register tracking, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got_r;
        if (!rst_n)
        begin
            avg_ticks_r    = AVG_TICKS_RST;
            tilt_limit_r   = TILT_LIMIT_RST;
            fall_ticks_r   = FALL_TICKS_RST;
            land_ticks_r   = LAND_TICKS_RST;
            knee_trigger_r = KNEE_TRIGGER_RST;
            avg_cnt        = 0;
            fall_cnt       = 0;
            land_cnt       = 0;
            for (int i = 0; i < LEGS; i++)
                knee_avg[i] = 0;
            landing_q      = 1'b0;
            falling_q      = 1'b0;
            ready_q        = 1'b0;
            gait_q         = 1'b0;
            owed_results.delete();
            mismatches     = 0;
            outstanding    = 0;
            checked        = 0;
            falls_seen     = 0;
            landings_seen  = 0;
            grants_seen    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_AVG_TICKS:    avg_ticks_r    = cfg_data[15:0];
                    REG_TILT_LIMIT:   tilt_limit_r   = cfg_data[14:0];
                    REG_FALL_TICKS:   fall_ticks_r   = cfg_data[15:0];
                    REG_LAND_TICKS:   land_ticks_r   = cfg_data[15:0];
                    REG_KNEE_TRIGGER: knee_trigger_r = cfg_data[14:0];
                    default: ;
                endcase
            end

            // Push before pop so a result in the same cycle as its tick would still line up
            if (tick_valid && tick_ready)
            begin
                advance_detector(tick_data, exp_r);
                owed_results.push_back(exp_r);
            end

            if (result_valid && result_ready)
            begin
                got_r = result_data;
                if (owed_results.size() == 0)
                begin
                    $error("result transaction with no tick awaiting it");
                    mismatches++;
                end
                else
                begin
                    exp_r = owed_results.pop_front();
                    check_field("ready_res",   exp_r.ready_res,   got_r.ready_res);
                    check_field("landed",      exp_r.landed,      got_r.landed);
                    check_field("fallen",      exp_r.fallen,      got_r.fallen);
                    check_field("gait_select", exp_r.gait_select, got_r.gait_select);
                    check_field("next_mode",   exp_r.next_mode,   got_r.next_mode);
                    check_field("switch_done", exp_r.switch_done, got_r.switch_done);
                    check_field("bad_request", exp_r.bad_request, got_r.bad_request);
                    checked++;
                    if (exp_r.fallen && exp_r.ready_res)
                        falls_seen++;
                    if (exp_r.landed && exp_r.ready_res)
                        landings_seen++;
                    if (exp_r.switch_done && exp_r.next_mode >= MODE_LOCOMOTION)
                        grants_seen++;
                end
            end

            outstanding = owed_results.size();
        end
    end

endmodule

>>> verif/tb_lift_landing_fall_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lift_landing_fall_detector
// Drives control ticks and register settings into the landing and fall
// detector: a directed opening, runs of level, triggered and tilted ticks
// under several settings, back pressure, and a burst under full-scale
// thresholds. The checker beside the block predicts and compares; this top
// judges.
// ----------------------------------------------------------------------------
module tb_lift_landing_fall_detector;
    import lld_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 185;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 2000;
    localparam int BURST_TICKS = 20;

    typedef enum int {ITEM_QUIET, ITEM_HIT, ITEM_TILT, ITEM_NOISE, ITEM_ENTER} item_kind_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lld_stream_if #(.T(tick_t))   tick_if ();
    lld_stream_if #(.T(result_t)) res_if ();

    int mismatches, outstanding, checked, falls_seen, landings_seen, grants_seen;

    // Stimulus-side copy of the settings, used to aim the ticks
    int cur_tilt, cur_trig, cur_fall, cur_land;
    int settings_used;
    bit idle_on;
    bit hold_go;

    lift_landing_fall_detector DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_if),
        .result    (res_if)
    );

    lld_detector_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .tick_valid    (tick_if.valid),
        .tick_ready    (tick_if.ready),
        .tick_data     (tick_if.data),
        .result_valid  (res_if.valid),
        .result_ready  (res_if.ready),
        .result_data   (res_if.data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked),
        .falls_seen    (falls_seen),
        .landings_seen (landings_seen),
        .grants_seen   (grants_seen)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result sink: random back pressure, or a long hold-off on request
    initial
    begin : result_sink
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            res_if.ready <= idle_on ? ($urandom_range(99) >= 18) : 1'b1;
        end
    end

    // Watchdog: too long without any transaction ends the run
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $error("no transaction for %0d cycles, %0d results owed", STALL_LIMIT, outstanding);
        $display("lift_landing_fall_detector verification failed");
        $finish;
    end

    function automatic logic signed [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic tick_t build_tick(input logic op, input int r, input int p,
                                         input int k0, input int k1, input int k2,
                                         input int k3, input logic [2:0] mode);
        tick_t t;
        t.opcode         = op;
        t.roll           = 16'(r);
        t.pitch          = 16'(p);
        t.knee_torque_0  = 16'(k0);
        t.knee_torque_1  = 16'(k1);
        t.knee_torque_2  = 16'(k2);
        t.knee_torque_3  = 16'(k3);
        t.requested_mode = mode;
        return t;
    endfunction

    // Mostly the gated modes, so grants get exercised
    function automatic logic [2:0] pick_mode();
        case ($urandom_range(9)) inside
            3, 4:    return MODE_LOCOMOTION;
            5, 6:    return MODE_QP_STAND;
            7, 8:    return MODE_RESET;
            9:       return MODE_BAD;
            default: return 3'($urandom_range(7));
        endcase
    endfunction

    // Random tick of a given kind, aimed at the current settings
    function automatic tick_t make_item(input item_kind_t kind, input logic [2:0] mode);
        tick_t t;
        int    lim, q, v;
        lim = cur_tilt;
        q   = cur_trig / 3;
        t.opcode         = OP_TICK;
        t.requested_mode = mode;
        t.roll           = 16'(int'($urandom_range(2 * lim)) - lim);
        t.pitch          = 16'(int'($urandom_range(2 * lim)) - lim);
        t.knee_torque_0  = 16'(int'($urandom_range(2 * q)) - q);
        t.knee_torque_1  = 16'(int'($urandom_range(2 * q)) - q);
        t.knee_torque_2  = 16'(int'($urandom_range(2 * q)) - q);
        t.knee_torque_3  = 16'(int'($urandom_range(2 * q)) - q);
        case (kind)
            ITEM_HIT:
            begin
                case ($urandom_range(3))
                    0:       v = cur_trig;
                    1:       v = -cur_trig;
                    2:       v = int'($signed(t.knee_torque_0)) + cur_trig;
                    default: v = rand16();
                endcase
                case ($urandom_range(3))
                    0:       t.knee_torque_0 = 16'(v);
                    1:       t.knee_torque_1 = 16'(v);
                    2:       t.knee_torque_2 = 16'(v);
                    default: t.knee_torque_3 = 16'(v);
                endcase
            end
            ITEM_TILT:
            begin
                v = int'($urandom_range(32767, lim + 1));
                if ($urandom_range(1))
                    v = -v;
                if ($urandom_range(15) == 0)
                    v = -32768;
                case ($urandom_range(2))
                    0:       t.roll = 16'(v);
                    1:       t.pitch = 16'(v);
                    default:
                    begin
                        t.roll  = 16'(v);
                        t.pitch = 16'(-v);
                    end
                endcase
            end
            ITEM_NOISE:
            begin
                t.opcode         = ($urandom_range(7) == 0) ? OP_ENTER : OP_TICK;
                t.roll           = rand16();
                t.pitch          = rand16();
                t.knee_torque_0  = rand16();
                t.knee_torque_1  = rand16();
                t.knee_torque_2  = rand16();
                t.knee_torque_3  = rand16();
                t.requested_mode = 3'($urandom);
            end
            ITEM_ENTER:
            begin
                t.opcode = OP_ENTER;
            end
            default: ;
        endcase
        return t;
    endfunction

    // Offer one tick, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_tick(input tick_t t);
        if (idle_on)
            while ($urandom_range(99) < 18)
            begin
                tick_if.valid <= 1'b0;
                @(negedge clk);
            end
        tick_if.valid <= 1'b1;
        tick_if.data  <= t;
        forever
        begin
            @(posedge clk);
            if (tick_if.ready)
                break;
        end
        @(negedge clk);
    endtask

    // Stop offering and wait until every owed result has arrived
    task automatic wait_for_results();
        tick_if.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(negedge clk);
    endtask

    task automatic apply_settings(input int avg, input int tilt, input int fall,
                                  input int land, input int trig);
        write_reg(REG_AVG_TICKS, avg);
        write_reg(REG_TILT_LIMIT, tilt);
        write_reg(REG_FALL_TICKS, fall);
        write_reg(REG_LAND_TICKS, land);
        write_reg(REG_KNEE_TRIGGER, trig);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_tilt = tilt;
        cur_fall = fall;
        cur_land = land;
        cur_trig = trig;
        settings_used++;
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        item_kind_t kind;
        int         n, run_len, pick;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tick_if.valid = 1'b0;
        tick_if.data  = '0;
        idle_on       = 1'b1;
        hold_go       = 1'b0;
        settings_used = 0;
        cur_tilt      = TILT_LIMIT_RST;
        cur_trig      = KNEE_TRIGGER_RST;
        cur_fall      = FALL_TICKS_RST;
        cur_land      = LAND_TICKS_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: rounding ties, trigger thresholds, tilt edges, every mode
        apply_settings(2, 6434, 2, 2, 192);
        send_tick(build_tick(OP_TICK, 0, 0, 10, -10, 0, 5, MODE_DAMPER));
        // still averaging: tilt is ignored, means round half away from zero
        send_tick(build_tick(OP_TICK, 32767, -32768, 11, -11, 1, 6, MODE_BAD));
        // tilt exactly at the limit counts as level
        send_tick(build_tick(OP_TICK, 6434, -6434, 11, -11, 1, 6, MODE_LOCOMOTION));
        // deviation alone on a middle leg
        send_tick(build_tick(OP_TICK, 0, 0, 11, -11, -191, 6, MODE_QP_STAND));
        send_tick(build_tick(OP_TICK, 0, 0, 11, -11, -191, 6, MODE_QP_STAND));
        // magnitude alone on the first leg
        send_tick(build_tick(OP_TICK, 0, 0, 192, -11, 1, 6, MODE_LOCOMOTION));
        // one below the trigger on deviation, twelve below on magnitude
        send_tick(build_tick(OP_TICK, 0, 0, 11, 180, 1, 6, MODE_LOCOMOTION));
        // last leg only
        send_tick(build_tick(OP_TICK, 0, 0, 11, -11, 1, 198, MODE_LOCOMOTION));
        // just past the tilt limit, then falling confirmed
        send_tick(build_tick(OP_TICK, 6435, 0, 11, -11, 1, 6, MODE_RESET));
        send_tick(build_tick(OP_TICK, 0, -6435, 11, -11, 1, 6, MODE_RESET));
        send_tick(build_tick(OP_TICK, -32768, 0, 11, -11, 1, 6, MODE_RESET));
        send_tick(build_tick(OP_TICK, 0, 32767, 11, -11, 1, 6, MODE_LIFTED));
        send_tick(build_tick(OP_TICK, 0, 0, 11, -11, 1, 6, MODE_RESET));
        // enter keeps landing and falling but clears ready; the next tick rebuilds the mean from scratch
        send_tick(build_tick(OP_ENTER, 0, 0, 11, -11, 1, 6, MODE_RECOVERY));
        send_tick(build_tick(OP_TICK, 0, 0, -32768, 32767, -32768, 32767, MODE_OFF));
        send_tick(build_tick(OP_TICK, 0, 0, 32767, -32768, 32767, -32768, MODE_OFF));
        send_tick(build_tick(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_LOCOMOTION));
        wait_for_results();

        // No averaging at all: the held means are used straight away
        apply_settings(0, 6434, 1, 1, 192);
        send_tick(build_tick(OP_ENTER, 0, 0, 0, 0, 0, 0, MODE_LIFTED));
        send_tick(build_tick(OP_TICK, 0, 0, 0, 0, 0, 500, MODE_LOCOMOTION));
        send_tick(build_tick(OP_TICK, 9000, 0, 0, 0, 0, 0, MODE_RESET));
        send_tick(build_tick(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_QP_STAND));

        // Random phases, each under its own settings
        for (int p = 0; p < PHASES; p++)
        begin
            wait_for_results();
            case (p)
                0:       apply_settings(1, 0, 1, 1, 0);
                1:       apply_settings(65535, 25736, 65535, 65535, 32767);
                2:       apply_settings(1, 25736, 1, 1, 32767);
                default: apply_settings($urandom_range(6, 1), $urandom_range(25736, 200),
                                        $urandom_range(8, 1), $urandom_range(8, 1),
                                        $urandom_range(3000, 16));
            endcase
            idle_on = (p != 5);
            if ($urandom_range(1))
                send_tick(make_item(ITEM_ENTER, pick_mode()));
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                begin
                    kind    = ITEM_QUIET;
                    run_len = $urandom_range(6, 1);
                end
                else if (pick < 65)
                begin
                    kind    = ITEM_HIT;
                    run_len = $urandom_range(((cur_land < 12) ? cur_land : 12) + 2, 1);
                end
                else if (pick < 88)
                begin
                    kind    = ITEM_TILT;
                    run_len = $urandom_range(((cur_fall < 12) ? cur_fall : 12) + 2, 1);
                end
                else if (pick < 97)
                begin
                    kind    = ITEM_NOISE;
                    run_len = $urandom_range(3, 1);
                end
                else
                begin
                    kind    = ITEM_ENTER;
                    run_len = 1;
                end
                repeat (run_len)
                begin
                    send_tick(make_item(kind, pick_mode()));
                    n++;
                    // back pressure long enough to fill the block
                    if (p == 3 && n == 60)
                        hold_go = 1'b1;
                    // sender pause until everything is back
                    if (p == 4 && n == 90)
                        wait_for_results();
                end
            end
        end

        // Full-scale thresholds: tilted and triggered bursts never confirm, no idling
        wait_for_results();
        idle_on = 1'b0;
        apply_settings(1, 6434, 65535, 65535, 192);
        send_tick(make_item(ITEM_ENTER, pick_mode()));
        send_tick(build_tick(OP_TICK, 0, 0, 0, 0, 0, 0, MODE_LIFTED));
        repeat (BURST_TICKS)
            send_tick(make_item(ITEM_TILT, pick_mode()));
        repeat (BURST_TICKS)
            send_tick(build_tick(OP_TICK, 0, 0, 1000, 0, 0, 0, pick_mode()));
        wait_for_results();

        $display("Covered %0d ticks under %0d register settings, full-scale thresholds included.",
                 checked, settings_used);
        $display("Confirmed falls %0d, confirmed landings %0d, gated mode grants %0d.",
                 falls_seen, landings_seen, grants_seen);
        if (mismatches == 0)
            $display("lift_landing_fall_detector verification clean");
        else
            $display("lift_landing_fall_detector verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/lld_pkg.sv
design/lld_stream_if.sv
design/lift_landing_fall_detector.sv
verif/lld_detector_checker.sv
verif/tb_lift_landing_fall_detector.sv
